### hdl/chr_pkg.sv
// shared types and constants for the command history ring
`timescale 1ns / 1ps
`default_nettype none
package chr_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int LINE_LENGTH   = 64;

    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int LEN_W   = $clog2(LINE_LENGTH + 1);
    localparam int STORE_DEPTH = HISTORY_DEPTH * LINE_LENGTH;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int CHAR_W  = 8;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_OLDER  = 2'd1;
    localparam logic [OP_W-1:0] OP_NEWER  = 2'd2;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [CHAR_W-1:0] char_in;
    } t_cmd;

    typedef struct packed {
        logic              ok;
        logic [CHAR_W-1:0] char_out;
        logic              has_char;
        logic              last;
    } t_result;

    typedef struct packed {
        logic accept;
        logic read;
    } t_ctrl_cmd;

    typedef struct packed {
        logic stream_go;
        logic last_read;
    } t_dp_status;

endpackage
`default_nettype wire

### hdl/chr_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module chr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### hdl/chr_ctrl.sv
// controller state machine for the command history ring
`timescale 1ns / 1ps
`default_nettype none
module chr_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    input  wire chr_pkg::t_dp_status i_status,
    output chr_pkg::t_ctrl_cmd       o_cmd,
    output logic                     o_busy
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_STREAM = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.accept = 1'b0;
        o_cmd.read   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_start;
                if (i_start && i_status.stream_go) begin
                    n_state = ST_STREAM;
                end
            end
            ST_STREAM: begin
                o_cmd.read = 1'b1;
                if (i_status.last_read) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state == ST_STREAM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### hdl/chr_dp.sv
// datapath: ring pointers, browse cursor, line lengths and line store
`timescale 1ns / 1ps
`default_nettype none
module chr_dp (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire chr_pkg::t_ctrl_cmd  i_cmd,
    input  wire chr_pkg::t_cmd       i_item,
    output chr_pkg::t_dp_status      o_status,
    output logic                     o_result_valid,
    output chr_pkg::t_result         o_result
);

    localparam int SW = chr_pkg::SLOT_W;
    localparam int CW = chr_pkg::COUNT_W;
    localparam int LW = chr_pkg::LEN_W;
    localparam int AW = chr_pkg::ADDR_W;

    logic [SW-1:0] r_wr_slot, n_wr_slot;
    logic [CW-1:0] r_count, n_count;
    logic          r_browsing, n_browsing;
    logic [SW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_pending, n_pending;
    logic [LW-1:0] r_len [chr_pkg::HISTORY_DEPTH];
    logic [SW-1:0] r_sel_slot, n_sel_slot;
    logic [LW-1:0] r_sel_len, n_sel_len;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_rd_pend, n_rd_pend;
    logic          r_rd_last, n_rd_last;
    chr_pkg::t_result r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic [SW-1:0] c_slot;
    logic [CW-1:0] c_count;
    logic          c_browsing;
    logic [SW-1:0] c_pos;
    logic          commit;
    logic          emit;
    logic [SW-1:0] e_pos;
    logic [SW:0]   sel_sum;
    logic [SW-1:0] sel_slot;
    logic [LW-1:0] sel_len;
    logic          len_we;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [chr_pkg::CHAR_W-1:0] ram_rdata;
    logic          last_read;

    assign last_read = ((r_idx + LW'(1)) == r_sel_len);

    always_comb begin
        n_wr_slot   = r_wr_slot;
        n_count     = r_count;
        n_browsing  = r_browsing;
        n_pos       = r_pos;
        n_pending   = r_pending;
        n_sel_slot  = r_sel_slot;
        n_sel_len   = r_sel_len;
        n_idx       = r_idx;
        n_rd_pend   = 1'b0;
        n_rd_last   = r_rd_last;
        n_out       = r_out;
        n_out_valid = 1'b0;
        len_we      = 1'b0;
        ram_we      = 1'b0;
        emit        = 1'b0;
        e_pos       = '0;
        o_status.stream_go = 1'b0;
        o_status.last_read = last_read;

        commit = (r_pending != '0)
                 && ((i_item.opcode != chr_pkg::OP_PUSH) || (i_item.char_in == '0));

        // state once the pending line is committed
        c_slot     = r_wr_slot;
        c_count    = r_count;
        c_browsing = r_browsing;
        c_pos      = r_pos;
        if (commit) begin
            c_slot = (r_wr_slot == SW'(chr_pkg::HISTORY_DEPTH - 1)) ? '0
                                                                     : r_wr_slot + SW'(1);
            if (r_count < CW'(chr_pkg::HISTORY_DEPTH)) begin
                c_count = r_count + CW'(1);
            end
            c_browsing = 1'b0;
            c_pos      = '0;
        end

        ram_waddr = AW'(r_wr_slot) * AW'(chr_pkg::LINE_LENGTH) + AW'(r_pending);
        ram_raddr = AW'(r_sel_slot) * AW'(chr_pkg::LINE_LENGTH) + AW'(r_idx);

        if (i_cmd.accept) begin
            if (commit) begin
                len_we    = 1'b1;
                n_pending = '0;
            end
            n_wr_slot  = c_slot;
            n_count    = c_count;
            n_browsing = c_browsing;
            n_pos      = c_pos;
            n_out.char_out = '0;
            n_out.has_char = 1'b0;
            n_out.last     = 1'b1;
            n_out.ok       = 1'b0;
            case (i_item.opcode)
                chr_pkg::OP_PUSH: begin
                    if ((i_item.char_in != '0)
                        && (r_pending < LW'(chr_pkg::LINE_LENGTH))) begin
                        ram_we    = 1'b1;
                        n_pending = r_pending + LW'(1);
                    end
                end
                chr_pkg::OP_OLDER: begin
                    if (c_count == '0) begin
                        n_out_valid = 1'b1;
                    end else if (!c_browsing) begin
                        n_browsing = 1'b1;
                        n_pos      = '0;
                        emit       = 1'b1;
                        e_pos      = '0;
                    end else if ((CW'(c_pos) + CW'(1)) < c_count) begin
                        n_pos = c_pos + SW'(1);
                        emit  = 1'b1;
                        e_pos = c_pos + SW'(1);
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
                chr_pkg::OP_NEWER: begin
                    if (!c_browsing) begin
                        n_out_valid = 1'b1;
                    end else if (c_pos == '0) begin
                        n_browsing  = 1'b0;
                        n_out_valid = 1'b1;
                        n_out.ok    = 1'b1;
                    end else begin
                        n_pos = c_pos - SW'(1);
                        emit  = 1'b1;
                        e_pos = c_pos - SW'(1);
                    end
                end
                chr_pkg::OP_CANCEL: begin
                    n_browsing = 1'b0;
                    n_pos      = '0;
                end
                default: begin
                    n_browsing = c_browsing;
                end
            endcase
        end

        // selected slot counted back from the newest entry
        sel_sum = {1'b0, c_slot} + (SW + 1)'(chr_pkg::HISTORY_DEPTH - 1) - {1'b0, e_pos};
        if (sel_sum >= (SW + 1)'(chr_pkg::HISTORY_DEPTH)) begin
            sel_slot = SW'(sel_sum - (SW + 1)'(chr_pkg::HISTORY_DEPTH));
        end else begin
            sel_slot = SW'(sel_sum);
        end
        // bypass a length committed by this same transfer
        if (commit && (sel_slot == r_wr_slot)) begin
            sel_len = r_pending;
        end else begin
            sel_len = r_len[sel_slot];
        end

        if (emit) begin
            if (sel_len == '0) begin
                n_out_valid = 1'b1;
                n_out.ok    = 1'b1;
            end else begin
                o_status.stream_go = 1'b1;
                n_sel_slot = sel_slot;
                n_sel_len  = sel_len;
                n_idx      = '0;
            end
        end

        if (i_cmd.read) begin
            n_idx     = r_idx + LW'(1);
            n_rd_pend = 1'b1;
            n_rd_last = last_read;
        end
    end

    chr_ram #(
        .WIDTH(chr_pkg::CHAR_W),
        .DEPTH(chr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_item.char_in),
        .i_re   (i_cmd.read),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len[r_wr_slot] <= r_pending;
        end
        r_sel_slot <= n_sel_slot;
        r_sel_len  <= n_sel_len;
        r_idx      <= n_idx;
        r_rd_last  <= n_rd_last;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot   <= '0;
            r_count     <= '0;
            r_browsing  <= 1'b0;
            r_pos       <= '0;
            r_pending   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_slot   <= n_wr_slot;
            r_count     <= n_count;
            r_browsing  <= n_browsing;
            r_pos       <= n_pos;
            r_pending   <= n_pending;
            r_rd_pend   <= n_rd_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_result_valid = r_rd_pend | r_out_valid;

    always_comb begin
        if (r_rd_pend) begin
            o_result.ok       = 1'b1;
            o_result.char_out = ram_rdata;
            o_result.has_char = 1'b1;
            o_result.last     = r_rd_last;
        end else begin
            o_result = r_out;
        end
    end

endmodule
`default_nettype wire

### hdl/command_history_ring.sv
// top level of the command history ring: controller plus datapath
// push and cancel are accepted with busy staying low
// a failure or empty browse result appears in the cycle after the transfer
// a recalled line of n characters streams one per cycle, after the selected slot and
// then the line store read are registered; busy is high while the line store is read
// reset is synchronous, active low; the line store and lengths are not cleared
`timescale 1ns / 1ps
`default_nettype none
module command_history_ring (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    input  wire chr_pkg::t_cmd i_cmd,
    output logic               busy,
    output logic               o_result_valid,
    output chr_pkg::t_result   o_result
);

    chr_pkg::t_ctrl_cmd  ctrl_cmd;
    chr_pkg::t_dp_status dp_status;

    chr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_status(dp_status),
        .o_cmd   (ctrl_cmd),
        .o_busy  (busy)
    );

    chr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (ctrl_cmd),
        .i_item        (i_cmd),
        .o_status      (dp_status),
        .o_result_valid(o_result_valid),
        .o_result      (o_result)
    );

endmodule
`default_nettype wire

### tb/sv/command_history_ring_test.sv
// self-checking testbench for the command history ring: directed table, then random traffic
`timescale 1ns / 1ps
`default_nettype none
module command_history_ring_test;
    import chr_pkg::*;

    localparam int N_ITEMS = 500;

    localparam t_result FAIL_RES  = '{ok: 1'b0, char_out: 8'h00, has_char: 1'b0, last: 1'b1};
    localparam t_result EMPTY_RES = '{ok: 1'b1, char_out: 8'h00, has_char: 1'b0, last: 1'b1};

    typedef struct packed {
        t_cmd    cmd;
        logic    typed;
        t_result want;
    } t_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    command_history_ring u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_cmd          (i_cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // predictor state
    logic [CHAR_W-1:0]  hist_chars [HISTORY_DEPTH][LINE_LENGTH];
    logic [LEN_W-1:0]   hist_len [HISTORY_DEPTH];
    logic [SLOT_W-1:0]  hist_wr;
    logic [COUNT_W-1:0] hist_count;
    logic [SLOT_W-1:0]  hist_pos;
    logic [LEN_W-1:0]   hist_pend;
    bit                 hist_browsing;

    t_result recall_q[$];
    t_result recalled[$];

    bit      use_typed;
    t_result typed_want;
    int      burst_left;

    int errors;
    int n_accepted;
    int n_pushes;
    int n_browses;
    int n_results;
    int n_commits;
    int n_full_commits;
    int n_dropped;

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 30) begin
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        end
    endtask

    function automatic void commit_line();
        if (hist_pend != '0) begin
            hist_len[hist_wr] = hist_pend;
            hist_wr = hist_wr + 1'b1;
            if (int'(hist_count) < HISTORY_DEPTH) begin
                hist_count = hist_count + 1'b1;
            end else begin
                n_full_commits++;
            end
            hist_browsing = 1'b0;
            hist_pos = '0;
            hist_pend = '0;
            n_commits++;
        end
    endfunction

    function automatic void recall_selected();
        logic [SLOT_W-1:0] slot;
        int n;
        t_result r;
        slot = hist_wr - 1'b1 - hist_pos;
        n = int'(hist_len[slot]);
        if (n == 0) begin
            recalled.push_back(EMPTY_RES);
        end else begin
            for (int i = 0; i < n; i++) begin
                r.ok = 1'b1;
                r.char_out = hist_chars[slot][i];
                r.has_char = 1'b1;
                r.last = (i == n - 1);
                recalled.push_back(r);
            end
        end
    endfunction

    function automatic void history_step(input t_cmd c);
        recalled.delete();
        if (c.opcode == OP_PUSH) begin
            n_pushes++;
            if (c.char_in == '0) begin
                commit_line();
            end else if (int'(hist_pend) < LINE_LENGTH) begin
                hist_chars[hist_wr][hist_pend] = c.char_in;
                hist_pend = hist_pend + 1'b1;
            end else begin
                n_dropped++;
            end
        end else begin
            commit_line();
            case (c.opcode)
                OP_OLDER: begin
                    n_browses++;
                    if (hist_count == '0) begin
                        recalled.push_back(FAIL_RES);
                    end else if (!hist_browsing) begin
                        hist_browsing = 1'b1;
                        hist_pos = '0;
                        recall_selected();
                    end else if (int'(hist_pos) + 1 < int'(hist_count)) begin
                        hist_pos = hist_pos + 1'b1;
                        recall_selected();
                    end else begin
                        recalled.push_back(FAIL_RES);
                    end
                end
                OP_NEWER: begin
                    n_browses++;
                    if (!hist_browsing) begin
                        recalled.push_back(FAIL_RES);
                    end else if (hist_pos == '0) begin
                        hist_browsing = 1'b0;
                        recalled.push_back(EMPTY_RES);
                    end else begin
                        hist_pos = hist_pos - 1'b1;
                        recall_selected();
                    end
                end
                default: begin
                    hist_browsing = 1'b0;
                    hist_pos = '0;
                end
            endcase
        end
    endfunction

    // result check first, then transfer of a command, both on pre-edge values
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n) begin
            if (o_result_valid) begin
                n_results++;
                if (recall_q.size() == 0) begin
                    report_mismatch("unexpected result", int'(o_result), 0);
                end else begin
                    want = recall_q.pop_front();
                    if (o_result.ok !== want.ok)
                        report_mismatch("ok", int'(o_result.ok), int'(want.ok));
                    if (o_result.char_out !== want.char_out)
                        report_mismatch("char_out", int'(o_result.char_out), int'(want.char_out));
                    if (o_result.has_char !== want.has_char)
                        report_mismatch("has_char", int'(o_result.has_char), int'(want.has_char));
                    if (o_result.last !== want.last)
                        report_mismatch("last", int'(o_result.last), int'(want.last));
                end
            end
            if (start && !busy) begin
                n_accepted++;
                history_step(i_cmd);
                if (use_typed) begin
                    recall_q.push_back(typed_want);
                end else begin
                    foreach (recalled[i]) recall_q.push_back(recalled[i]);
                end
            end
        end
    end

    // called at a falling edge; returns at a falling edge
    task automatic send(input t_cmd c, input bit typed, input t_result want);
        use_typed = typed;
        typed_want = want;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 10);
        end
    endtask

    task automatic drain_results();
        int n;
        n = 0;
        start <= 1'b0;
        do begin
            @(negedge i_clk);
            n++;
        end while (recall_q.size() != 0 && n < 2000);
        if (recall_q.size() != 0) begin
            report_mismatch("missing results", 0, recall_q.size());
            recall_q.delete();
        end
    endtask

    function automatic t_row step_row(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                                      input logic typed, input t_result want);
        t_row r;
        r.cmd.opcode = op;
        r.cmd.char_in = ch;
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    initial begin
        t_row directed[$];
        t_cmd c;
        int issued;
        int next_drain;
        int pick;
        int len;
        bit long_walk;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        use_typed = 1'b0;
        typed_want = '0;
        burst_left = 0;
        hist_wr = '0;
        hist_count = '0;
        hist_pos = '0;
        hist_pend = '0;
        hist_browsing = 1'b0;

        directed.push_back(step_row(OP_OLDER,  8'h00, 1'b1, FAIL_RES));
        directed.push_back(step_row(OP_NEWER,  8'h00, 1'b1, FAIL_RES));
        directed.push_back(step_row(OP_CANCEL, 8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_PUSH,   8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_NEWER,  8'hff, 1'b1, FAIL_RES));
        directed.push_back(step_row(OP_PUSH,   8'h01, 1'b0, '0));
        directed.push_back(step_row(OP_PUSH,   8'hff, 1'b0, '0));
        directed.push_back(step_row(OP_PUSH,   8'h80, 1'b0, '0));
        directed.push_back(step_row(OP_PUSH,   8'h7f, 1'b0, '0));
        directed.push_back(step_row(OP_PUSH,   8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_OLDER,  8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_OLDER,  8'h00, 1'b1, FAIL_RES));
        directed.push_back(step_row(OP_NEWER,  8'h00, 1'b1, EMPTY_RES));
        directed.push_back(step_row(OP_NEWER,  8'h00, 1'b1, FAIL_RES));
        directed.push_back(step_row(OP_PUSH,   8'h55, 1'b0, '0));
        directed.push_back(step_row(OP_PUSH,   8'haa, 1'b0, '0));
        directed.push_back(step_row(OP_OLDER,  8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_OLDER,  8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_PUSH,   8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_NEWER,  8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_CANCEL, 8'hff, 1'b0, '0));
        directed.push_back(step_row(OP_OLDER,  8'h00, 1'b0, '0));
        directed.push_back(step_row(OP_PUSH,   8'h42, 1'b0, '0));
        directed.push_back(step_row(OP_NEWER,  8'h00, 1'b1, FAIL_RES));
        directed.push_back(step_row(OP_OLDER,  8'h00, 1'b0, '0));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[i]) begin
            send(directed[i].cmd, directed[i].typed, directed[i].want);
        end
        drain_results();

        issued = 0;
        next_drain = 100;
        while (issued < N_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // type a line, usually short, now and then past the line length
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
                for (int k = 0; k < len; k++) begin
                    c.opcode = OP_PUSH;
                    c.char_in = CHAR_W'($urandom_range(1, 255));
                    send(c, 1'b0, '0);
                    issued++;
                end
                if ($urandom_range(0, 9) < 7) begin
                    c.opcode = OP_PUSH;
                    c.char_in = '0;
                    send(c, 1'b0, '0);
                    issued++;
                end
            end else if (pick < 85) begin
                // browse walk; long walks reach the oldest entry of a full ring
                long_walk = ($urandom_range(0, 4) == 0);
                len = long_walk ? $urandom_range(17, 20) : $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    c.opcode = (long_walk || $urandom_range(0, 2) != 0) ? OP_OLDER : OP_NEWER;
                    c.char_in = CHAR_W'($urandom);
                    send(c, 1'b0, '0);
                    issued++;
                end
            end else begin
                c.opcode = OP_W'($urandom_range(0, 3));
                c.char_in = ($urandom_range(0, 3) == 0) ? '0 : CHAR_W'($urandom);
                send(c, 1'b0, '0);
                issued++;
            end
            if (issued >= next_drain) begin
                drain_results();
                next_drain += 100;
            end
        end

        drain_results();
        repeat (80) @(negedge i_clk);

        $display("covered %0d commands (%0d pushes, %0d browses), %0d results checked",
                 n_accepted, n_pushes, n_browses, n_results);
        $display("%0d lines committed, %0d into a full ring, %0d characters past line length",
                 n_commits, n_full_commits, n_dropped);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
`default_nettype wire
